// ----- hw/rtl/rtch_pkg.sv -----
// ----------------------------------------------------------------------------
// rtch_pkg
// Shared types, widths and the multiply-accumulate program of the ray/triangle
// closest-hit unit.
// ----------------------------------------------------------------------------
package rtch_pkg;

  localparam int DIFF_W   = 33;
  localparam int CROSS_W  = 68;
  localparam int DET_W    = 104;
  localparam int DIV_W    = DET_W + 32;
  localparam int PROG_LEN = 24;
  localparam int PC_W     = 5;
  localparam int TAG_W    = 16;
  localparam int DIST_W   = 31;
  localparam int EPS_W    = 16;
  localparam int COORD_W  = 32;

  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [DET_W-1:0]   det_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z,
    CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z,
    CFG_MIN_DIST, CFG_T_INITIAL
  } cfg_index_t;

  typedef enum logic [3:0] {
    OP_A, OP_B, OP_C, OP_D, OP_E, OP_F, OP_G, OP_H, OP_I, OP_J, OP_K, OP_L
  } diff_sel_t;

  typedef enum logic [2:0] {X_M, X_N, X_P, X_Q, X_S, X_R} cross_sel_t;

  typedef enum logic [3:0] {
    D_NONE, D_M, D_N, D_P, D_Q, D_S, D_R, D_DEN, D_E1, D_E2, D_E3
  } dest_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_NORM, ST_CHECK, ST_DIV, ST_DONE
  } back_state_t;

  typedef struct packed {
    diff_sel_t  a_sel;
    logic       b_cross;
    diff_sel_t  b_diff;
    cross_sel_t b_x;
    logic       clr;
    logic       sub;
    dest_t      dest;
  } mac_op_t;

  // one queued triangle: edge and origin differences, first-of-ray flag and tag
  typedef struct packed {
    diff_t             a, b, d, e, f, h, i, j, l;
    logic              first;
    logic [TAG_W-1:0]  tag;
  } tri_item_t;

  typedef struct packed {
    logic   start;
    logic   clr;
    logic   sub;
    diff_t  a;
    cross_t b;
  } mac_req_t;

  typedef struct packed {
    logic start;
    det_t num;
    det_t den;
  } div_req_t;

  function automatic mac_op_t mk_op(input diff_sel_t a, input logic bc, input diff_sel_t bd,
                                    input cross_sel_t bx, input logic clr, input logic sub,
                                    input dest_t dest);
    mac_op_t o;
    o.a_sel   = a;
    o.b_cross = bc;
    o.b_diff  = bd;
    o.b_x     = bx;
    o.clr     = clr;
    o.sub     = sub;
    o.dest    = dest;
    return o;
  endfunction

  // cramer cofactors first, then the four determinants
  function automatic mac_op_t prog_op(input logic [PC_W-1:0] pc);
    mac_op_t o;
    case (pc)
      5'd0:  o = mk_op(OP_F, 1'b0, OP_K, X_M, 1'b1, 1'b0, D_NONE);
      5'd1:  o = mk_op(OP_G, 1'b0, OP_J, X_M, 1'b0, 1'b1, D_M);
      5'd2:  o = mk_op(OP_H, 1'b0, OP_K, X_M, 1'b1, 1'b0, D_NONE);
      5'd3:  o = mk_op(OP_G, 1'b0, OP_L, X_M, 1'b0, 1'b1, D_N);
      5'd4:  o = mk_op(OP_F, 1'b0, OP_L, X_M, 1'b1, 1'b0, D_NONE);
      5'd5:  o = mk_op(OP_H, 1'b0, OP_J, X_M, 1'b0, 1'b1, D_P);
      5'd6:  o = mk_op(OP_G, 1'b0, OP_I, X_M, 1'b1, 1'b0, D_NONE);
      5'd7:  o = mk_op(OP_E, 1'b0, OP_K, X_M, 1'b0, 1'b1, D_Q);
      5'd8:  o = mk_op(OP_E, 1'b0, OP_J, X_M, 1'b1, 1'b0, D_NONE);
      5'd9:  o = mk_op(OP_F, 1'b0, OP_I, X_M, 1'b0, 1'b1, D_S);
      5'd10: o = mk_op(OP_E, 1'b0, OP_L, X_M, 1'b1, 1'b0, D_NONE);
      5'd11: o = mk_op(OP_H, 1'b0, OP_I, X_M, 1'b0, 1'b1, D_R);
      5'd12: o = mk_op(OP_A, 1'b1, OP_A, X_M, 1'b1, 1'b0, D_NONE);
      5'd13: o = mk_op(OP_B, 1'b1, OP_A, X_Q, 1'b0, 1'b0, D_NONE);
      5'd14: o = mk_op(OP_C, 1'b1, OP_A, X_S, 1'b0, 1'b0, D_DEN);
      5'd15: o = mk_op(OP_D, 1'b1, OP_A, X_M, 1'b1, 1'b0, D_NONE);
      5'd16: o = mk_op(OP_B, 1'b1, OP_A, X_N, 1'b0, 1'b1, D_NONE);
      5'd17: o = mk_op(OP_C, 1'b1, OP_A, X_P, 1'b0, 1'b1, D_E1);
      5'd18: o = mk_op(OP_A, 1'b1, OP_A, X_N, 1'b1, 1'b0, D_NONE);
      5'd19: o = mk_op(OP_D, 1'b1, OP_A, X_Q, 1'b0, 1'b0, D_NONE);
      5'd20: o = mk_op(OP_C, 1'b1, OP_A, X_R, 1'b0, 1'b0, D_E2);
      5'd21: o = mk_op(OP_A, 1'b1, OP_A, X_P, 1'b1, 1'b0, D_NONE);
      5'd22: o = mk_op(OP_B, 1'b1, OP_A, X_R, 1'b0, 1'b1, D_NONE);
      5'd23: o = mk_op(OP_D, 1'b1, OP_A, X_S, 1'b0, 1'b0, D_E3);
      default: o = mk_op(OP_A, 1'b0, OP_A, X_M, 1'b1, 1'b0, D_NONE);
    endcase
    return o;
  endfunction

endpackage

// ----- hw/rtl/rtch_front.sv -----
// ----------------------------------------------------------------------------
// rtch_front
// Accepts triangles and forms the edge and origin differences for the queue.
// ----------------------------------------------------------------------------
module rtch_front (
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert0_x,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert0_y,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert0_z,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert1_x,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert1_y,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert1_z,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert2_x,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert2_y,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert2_z,
  input  logic                             in_first_of_ray,
  input  logic [rtch_pkg::TAG_W-1:0]       in_triangle_tag,
  input  logic signed [rtch_pkg::COORD_W-1:0] origin_x,
  input  logic signed [rtch_pkg::COORD_W-1:0] origin_y,
  input  logic signed [rtch_pkg::COORD_W-1:0] origin_z,
  input  logic                             q_full,
  output logic                             q_push,
  output rtch_pkg::tri_item_t              q_item
);
  import rtch_pkg::*;

  function automatic diff_t sub33(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y);
    return diff_t'(x) - diff_t'(y);
  endfunction

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.a     = sub33(in_vert0_x, in_vert1_x);
    q_item.b     = sub33(in_vert0_x, in_vert2_x);
    q_item.d     = sub33(in_vert0_x, origin_x);
    q_item.e     = sub33(in_vert0_y, in_vert1_y);
    q_item.f     = sub33(in_vert0_y, in_vert2_y);
    q_item.h     = sub33(in_vert0_y, origin_y);
    q_item.i     = sub33(in_vert0_z, in_vert1_z);
    q_item.j     = sub33(in_vert0_z, in_vert2_z);
    q_item.l     = sub33(in_vert0_z, origin_z);
    q_item.first = in_first_of_ray;
    q_item.tag   = in_triangle_tag;
  end

endmodule

// ----- hw/rtl/rtch_fifo.sv -----
// ----------------------------------------------------------------------------
// rtch_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module rtch_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rtch_pkg::tri_item_t push_item,
  input  logic                pop,
  output rtch_pkg::tri_item_t head,
  output logic                full,
  output logic                empty
);
  import rtch_pkg::*;

  tri_item_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/rtch_mac.sv -----
// ----------------------------------------------------------------------------
// rtch_mac
// Serial multiply-accumulate: a 68-bit operand times a 33-bit operand, one
// byte of the short operand per cycle, then a step for its sign bit.
// ----------------------------------------------------------------------------
module rtch_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  rtch_pkg::mac_req_t req,
  output logic               done,
  output rtch_pkg::det_t     acc
);
  import rtch_pkg::*;

  localparam int PP_W = CROSS_W + 9;

  diff_t                  a_r;
  cross_t                 b_r;
  det_t                   acc_r;
  logic [2:0]             cnt_r;
  logic                   busy_r, done_r;
  logic [7:0]             digit;
  logic signed [PP_W-1:0] pp;
  det_t                   pp_sh;

  always_comb begin
    digit = a_r[{cnt_r[1:0], 3'b000} +: 8];
    pp    = b_r * $signed({1'b0, digit});
    pp_sh = det_t'(pp) <<< {cnt_r[1:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.sub ? -req.b : req.b;
      if (req.clr) acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        acc_r <= acc_r + pp_sh;
      end else if (a_r[DIFF_W-1]) begin
        // top bit of the short operand weighs -2^32
        acc_r <= acc_r - (det_t'(b_r) <<< 32);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

// ----- hw/rtl/rtch_div.sv -----
// ----------------------------------------------------------------------------
// rtch_div
// Restoring divider, one quotient bit per cycle, 32 quotient bits. Bit 31 set
// means the quotient is at least 2^31.
// ----------------------------------------------------------------------------
module rtch_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rtch_pkg::div_req_t req,
  output logic               done,
  output logic [31:0]        quot
);
  import rtch_pkg::*;

  logic [DIV_W-1:0] rem_r, dsh_r;
  logic [31:0]      q_r;
  logic [4:0]       cnt_r;
  logic             busy_r, done_r;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DIV_W'($unsigned(req.num)) << FRAC_BITS;
      dsh_r <= DIV_W'($unsigned(req.den)) << 31;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- hw/rtl/rtch_back.sv -----
// ----------------------------------------------------------------------------
// rtch_back
// Runs the determinant program on the shared MAC, normalizes signs, tests the
// barycentric bounds, divides for the distance and keeps the closest hit.
// ----------------------------------------------------------------------------
module rtch_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  rtch_pkg::tri_item_t               q_head,
  output logic                              q_pop,
  input  logic signed [rtch_pkg::COORD_W-1:0] dir_x,
  input  logic signed [rtch_pkg::COORD_W-1:0] dir_y,
  input  logic signed [rtch_pkg::COORD_W-1:0] dir_z,
  input  logic [rtch_pkg::EPS_W-1:0]        min_distance,
  input  logic [rtch_pkg::DIST_W-1:0]       t_initial,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_is_hit,
  output logic [rtch_pkg::DIST_W-1:0]       out_closest_distance,
  output logic [rtch_pkg::TAG_W-1:0]        out_tag_out
);
  import rtch_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [PC_W-1:0]     pc_r;
  tri_item_t           it_r;
  cross_t              m_r, n_r, p_r, q_r, s_r, r_r;
  det_t                den_r, e1_r, e2_r, e3_r;
  logic [DIST_W-1:0]   closest_r;
  logic                hit_r;
  logic                out_valid_r, out_is_hit_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [TAG_W-1:0]    out_tag_r;

  mac_op_t             op;
  mac_req_t            mac_req;
  logic                mac_done;
  det_t                mac_acc;
  div_req_t            div_req;
  logic                div_done;
  logic [31:0]         quot;
  logic                out_free, geom_ok;
  logic [DET_W:0]      bary_sum;

  function automatic diff_t pick_diff(input diff_sel_t sel, input tri_item_t t,
                                      input diff_t c, input diff_t g, input diff_t k);
    diff_t v;
    unique case (sel)
      OP_A: v = t.a;
      OP_B: v = t.b;
      OP_C: v = c;
      OP_D: v = t.d;
      OP_E: v = t.e;
      OP_F: v = t.f;
      OP_G: v = g;
      OP_H: v = t.h;
      OP_I: v = t.i;
      OP_J: v = t.j;
      OP_K: v = k;
      OP_L: v = t.l;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op = prog_op(pc_r);
    mac_req.start = (state_r == ST_ISSUE);
    mac_req.clr   = op.clr;
    mac_req.sub   = op.sub;
    mac_req.a     = pick_diff(op.a_sel, it_r, diff_t'(dir_x), diff_t'(dir_y), diff_t'(dir_z));
    if (op.b_cross) begin
      unique case (op.b_x)
        X_M: mac_req.b = m_r;
        X_N: mac_req.b = n_r;
        X_P: mac_req.b = p_r;
        X_Q: mac_req.b = q_r;
        X_S: mac_req.b = s_r;
        X_R: mac_req.b = r_r;
        default: mac_req.b = '0;
      endcase
    end else begin
      mac_req.b = cross_t'(pick_diff(op.b_diff, it_r, diff_t'(dir_x), diff_t'(dir_y),
                                     diff_t'(dir_z)));
    end
  end

  rtch_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mac_req),
    .done (mac_done),
    .acc  (mac_acc)
  );

  // after normalization every value is non-negative when the test passes
  assign bary_sum = {1'b0, e1_r} + {1'b0, e2_r};
  assign geom_ok  = (den_r != '0) && !e1_r[DET_W-1] && !e2_r[DET_W-1] && !e3_r[DET_W-1]
                    && (bary_sum <= {1'b0, den_r});

  assign div_req.start = (state_r == ST_CHECK) && geom_ok;
  assign div_req.num   = e3_r;
  assign div_req.den   = den_r;

  rtch_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (!q_empty) state_nxt = ST_ISSUE;
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mac_done) state_nxt = (pc_r == PC_W'(PROG_LEN - 1)) ? ST_NORM : ST_ISSUE;
      end
      ST_NORM:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = geom_ok ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r <= q_head;
    end
    if (state_r == ST_WAIT && mac_done) begin
      unique case (op.dest)
        D_NONE: ;
        D_M:    m_r   <= mac_acc[CROSS_W-1:0];
        D_N:    n_r   <= mac_acc[CROSS_W-1:0];
        D_P:    p_r   <= mac_acc[CROSS_W-1:0];
        D_Q:    q_r   <= mac_acc[CROSS_W-1:0];
        D_S:    s_r   <= mac_acc[CROSS_W-1:0];
        D_R:    r_r   <= mac_acc[CROSS_W-1:0];
        D_DEN:  den_r <= mac_acc;
        D_E1:   e1_r  <= mac_acc;
        D_E2:   e2_r  <= mac_acc;
        D_E3:   e3_r  <= mac_acc;
        default: ;
      endcase
    end
    if (state_r == ST_NORM && den_r[DET_W-1]) begin
      den_r <= -den_r;
      e1_r  <= -e1_r;
      e2_r  <= -e2_r;
      e3_r  <= -e3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= '0;
      closest_r    <= {DIST_W{1'b1}};
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      out_is_hit_r <= 1'b0;
      out_dist_r   <= '0;
      out_tag_r    <= '0;
    end else begin
      if (q_pop) begin
        pc_r  <= '0;
        hit_r <= 1'b0;
        if (q_head.first) closest_r <= t_initial;
      end
      if (state_r == ST_WAIT && mac_done) pc_r <= pc_r + PC_W'(1);
      if (state_r == ST_DIV && div_done) begin
        // strictly between epsilon and the closest distance so far
        if (!quot[31] && (quot[30:0] > DIST_W'(min_distance))
            && (quot[30:0] < closest_r)) begin
          hit_r     <= 1'b1;
          closest_r <= quot[30:0];
        end
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r  <= 1'b1;
        out_is_hit_r <= hit_r;
        out_dist_r   <= closest_r;
        out_tag_r    <= it_r.tag;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_is_hit           = out_is_hit_r;
  assign out_closest_distance = out_dist_r;
  assign out_tag_out          = out_tag_r;

endmodule

// ----- hw/rtl/ray_triangle_closest_hit_unit.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_unit
// Ray against triangle stream, Cramer's rule form, closest hit tracking.
// ----------------------------------------------------------------------------
// The ray (origin, direction, epsilon, starting distance) is held in
// configuration registers; each input transaction is one triangle and yields
// exactly one result transaction with the hit flag, the closest distance after
// the test and the echoed tag. The 24 exact products of a triangle run one
// after another on a single 68x33-bit serial multiply-accumulate unit (a
// byte of the short operand per cycle), followed by sign normalization, the
// barycentric test and a 32-step restoring divider for the distance. A
// two-entry queue lets the next two triangles be taken while one is at work,
// and the output register lets a finished result wait without stopping it.
// Coordinates and directions are two's complement fixed point with FRAC_BITS
// fraction bits; epsilon and distances are unsigned on the same scale.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [rtch_pkg::COORD_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert0_x,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert0_y,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert0_z,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert1_x,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert1_y,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert1_z,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert2_x,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert2_y,
  input  logic signed [rtch_pkg::COORD_W-1:0] in_vert2_z,
  input  logic                                in_first_of_ray,
  input  logic [rtch_pkg::TAG_W-1:0]          in_triangle_tag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_hit,
  output logic [rtch_pkg::DIST_W-1:0]         out_closest_distance,
  output logic [rtch_pkg::TAG_W-1:0]          out_tag_out
);
  import rtch_pkg::*;

  logic signed [COORD_W-1:0] origin_x_r, origin_y_r, origin_z_r;
  logic signed [COORD_W-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic [EPS_W-1:0]          min_dist_r;
  logic [DIST_W-1:0]         t_init_r;

  tri_item_t push_item, head;
  logic      push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      dir_x_r    <= '0;
      dir_y_r    <= '0;
      dir_z_r    <= COORD_W'(1) << FRAC_BITS;
      min_dist_r <= EPS_W'(1);
      t_init_r   <= {DIST_W{1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ORIGIN_X:  origin_x_r <= cfg_data;
        CFG_ORIGIN_Y:  origin_y_r <= cfg_data;
        CFG_ORIGIN_Z:  origin_z_r <= cfg_data;
        CFG_DIR_X:     dir_x_r    <= cfg_data;
        CFG_DIR_Y:     dir_y_r    <= cfg_data;
        CFG_DIR_Z:     dir_z_r    <= cfg_data;
        CFG_MIN_DIST:  min_dist_r <= cfg_data[EPS_W-1:0];
        CFG_T_INITIAL: t_init_r   <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  rtch_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_vert0_x     (in_vert0_x),
    .in_vert0_y     (in_vert0_y),
    .in_vert0_z     (in_vert0_z),
    .in_vert1_x     (in_vert1_x),
    .in_vert1_y     (in_vert1_y),
    .in_vert1_z     (in_vert1_z),
    .in_vert2_x     (in_vert2_x),
    .in_vert2_y     (in_vert2_y),
    .in_vert2_z     (in_vert2_z),
    .in_first_of_ray(in_first_of_ray),
    .in_triangle_tag(in_triangle_tag),
    .origin_x       (origin_x_r),
    .origin_y       (origin_y_r),
    .origin_z       (origin_z_r),
    .q_full         (full),
    .q_push         (push),
    .q_item         (push_item)
  );

  rtch_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  rtch_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (empty),
    .q_head              (head),
    .q_pop               (pop),
    .dir_x               (dir_x_r),
    .dir_y               (dir_y_r),
    .dir_z               (dir_z_r),
    .min_distance        (min_dist_r),
    .t_initial           (t_init_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_hit          (out_is_hit),
    .out_closest_distance(out_closest_distance),
    .out_tag_out         (out_tag_out)
  );

endmodule

// ----- tb/sv/ray_triangle_closest_hit_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_unit_tb
// Drives triangle streams at several ray settings and checks every result
// against an exact wide-integer Cramer's rule predictor of the closest hit.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_unit_tb;
  import rtch_pkg::*;

  localparam int  FRAC      = 16;
  localparam int  LIMIT_CYC = 3000000;
  localparam int  ONE       = 1 << FRAC;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [31:0] v[9];
    logic               first;
    logic [15:0]        tag;
  } tri_t;

  typedef struct {
    logic        hit;
    logic [30:0] dist_val;
    logic [15:0] tag;
  } hit_result_t;

  class hit_scoreboard;
    logic signed [31:0] org[3];
    logic signed [31:0] dir[3];
    logic [15:0]        min_dist;
    logic [30:0]        t_init;
    wide_t              closest;
    hit_result_t        pending[$];
    int                 errors;

    function new();
      org = '{0, 0, 0};
      dir = '{0, 0, ONE};
      min_dist = 16'd1;
      t_init = 31'h7FFFFFFF;
      closest = 31'h7FFFFFFF;
      errors = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [31:0] val);
      case (idx)
        CFG_ORIGIN_X:  org[0] = val;
        CFG_ORIGIN_Y:  org[1] = val;
        CFG_ORIGIN_Z:  org[2] = val;
        CFG_DIR_X:     dir[0] = val;
        CFG_DIR_Y:     dir[1] = val;
        CFG_DIR_Z:     dir[2] = val;
        CFG_MIN_DIST:  min_dist = val[15:0];
        CFG_T_INITIAL: t_init = val[30:0];
        default: ;
      endcase
    endfunction

    // exact cramer solve, then closest-distance update
    function void note_input(tri_t t);
      wide_t a, b, c, d, e, f, g, h, i, j, k, l;
      wide_t m, n, p, q, s, r, den, e1, e2, e3, num, lo, hi, md;
      hit_result_t x;
      a = wide_t'(t.v[0]) - wide_t'(t.v[3]);
      b = wide_t'(t.v[0]) - wide_t'(t.v[6]);
      c = wide_t'(dir[0]);
      d = wide_t'(t.v[0]) - wide_t'(org[0]);
      e = wide_t'(t.v[1]) - wide_t'(t.v[4]);
      f = wide_t'(t.v[1]) - wide_t'(t.v[7]);
      g = wide_t'(dir[1]);
      h = wide_t'(t.v[1]) - wide_t'(org[1]);
      i = wide_t'(t.v[2]) - wide_t'(t.v[5]);
      j = wide_t'(t.v[2]) - wide_t'(t.v[8]);
      k = wide_t'(dir[2]);
      l = wide_t'(t.v[2]) - wide_t'(org[2]);
      m = f * k - g * j;
      n = h * k - g * l;
      p = f * l - h * j;
      q = g * i - e * k;
      s = e * j - f * i;
      r = e * l - h * i;
      den = a * m + b * q + c * s;
      e1 = d * m - b * n - c * p;
      e2 = a * n + d * q + c * r;
      e3 = a * p - b * r + d * s;
      x.hit = 1'b0;
      if (t.first) closest = t_init;
      if (den != 0) begin
        if (den < 0) begin
          den = -den;
          e1 = -e1;
          e2 = -e2;
          e3 = -e3;
        end
        if (e1 >= 0 && e2 >= 0 && e1 + e2 <= den && e3 >= 0) begin
          md = min_dist;
          num = e3 * ONE;
          lo = (md + 1) * den;
          hi = closest * den;
          if (num >= lo && num < hi) begin
            closest = num / den;
            x.hit = 1'b1;
          end
        end
      end
      x.dist_val = closest[30:0];
      x.tag = t.tag;
      pending.push_back(x);
    endfunction

    task report(string what);
      $display("error at %0t: %s", $time, what);
      errors++;
    endtask

    task check(logic hit, logic [30:0] dist_in, logic [15:0] tag);
      hit_result_t x;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result tag %h", tag));
        return;
      end
      x = pending.pop_front();
      if (hit !== x.hit)
        report($sformatf("tag %h is_hit %b, want %b", x.tag, hit, x.hit));
      if (dist_in !== x.dist_val)
        report($sformatf("tag %h closest_distance %h, want %h", x.tag, dist_in, x.dist_val));
      if (tag !== x.tag)
        report($sformatf("tag_out %h, want %h", tag, x.tag));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic signed [31:0] vx[9];
  logic        in_first_of_ray;
  logic [15:0] in_triangle_tag;
  logic        out_valid;
  logic        out_stall;
  logic        out_is_hit;
  logic [30:0] out_closest_distance;
  logic [15:0] out_tag_out;

  hit_scoreboard sb;
  bit            calm;
  int            cycles;
  logic signed [31:0] ray_o[3];
  logic signed [31:0] ray_d[3];

  ray_triangle_closest_hit_unit #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vert0_x(vx[0]), .in_vert0_y(vx[1]), .in_vert0_z(vx[2]),
    .in_vert1_x(vx[3]), .in_vert1_y(vx[4]), .in_vert1_z(vx[5]),
    .in_vert2_x(vx[6]), .in_vert2_y(vx[7]), .in_vert2_z(vx[8]),
    .in_first_of_ray(in_first_of_ray), .in_triangle_tag(in_triangle_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_hit(out_is_hit), .out_closest_distance(out_closest_distance),
    .out_tag_out(out_tag_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("ray_triangle_closest_hit_unit: mismatch");
      $finish;
    end
  end

  // result side: check accepted transactions, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check(out_is_hit, out_closest_distance, out_tag_out);
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 16);
  end

  function automatic int srand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send(tri_t t);
    in_valid <= 1'b1;
    for (int n = 0; n < 9; n++) vx[n] <= t.v[n];
    in_first_of_ray <= t.first;
    in_triangle_tag <= t.tag;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // vertices in Q16.16 whole units, for the directed part
  task automatic send_units(int x0, int y0, int z0, int x1, int y1, int z1,
                            int x2, int y2, int z2, bit first, logic [15:0] tag);
    tri_t t;
    t.v = '{x0 * ONE, y0 * ONE, z0 * ONE, x1 * ONE, y1 * ONE, z1 * ONE,
            x2 * ONE, y2 * ONE, z2 * ONE};
    t.first = first;
    t.tag = tag;
    send(t);
  endtask

  task automatic send_raw(logic [31:0] val, bit first, logic [15:0] tag);
    tri_t t;
    foreach (t.v[n]) t.v[n] = val;
    t.first = first;
    t.tag = tag;
    send(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [15:0] eps, logic [30:0] tinit);
    logic [31:0] vals[8];
    vals = '{ox, oy, oz, dx, dy, dz, {16'd0, eps}, {1'b0, tinit}};
    ray_o = '{ox, oy, oz};
    ray_d = '{dx, dy, dz};
    for (int n = 0; n < 8; n++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_index_t'(n);
      cfg_data <= vals[n];
      @(posedge clk);
      sb.set_reg(cfg_index_t'(n), vals[n]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // triangle around a point on the ray, centroid-ish so most contain it
  task automatic send_on_ray(bit first);
    tri_t   t;
    longint hop, pt[3], u[3], w[3];
    hop = longint'($urandom_range(1, 1 << 22));
    for (int n = 0; n < 3; n++) begin
      pt[n] = longint'(ray_o[n]) + ((longint'(ray_d[n]) * hop) >>> FRAC);
      u[n] = longint'(srand(1 << 18));
      w[n] = longint'(srand(1 << 18));
      t.v[n]     = 32'(pt[n] + u[n]);
      t.v[n + 3] = 32'(pt[n] + w[n]);
      t.v[n + 6] = 32'(pt[n] - u[n] - w[n] + longint'(srand(1 << 12)));
    end
    t.first = first;
    t.tag = 16'($urandom);
    send(t);
  endtask

  task automatic send_noise();
    tri_t t;
    foreach (t.v[n]) t.v[n] = $urandom;
    t.first = $urandom_range(0, 1);
    t.tag = $urandom;
    send(t);
  endtask

  initial begin
    int item_no;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    foreach (vx[n]) vx[n] = '0;
    in_first_of_ray = 1'b0;
    in_triangle_tag = '0;
    out_stall = 1'b0;
    calm = 1'b0;
    cycles = 0;
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, ONE};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default ray: from the origin along +z
    send_units(-1, -1, 5, 3, -1, 5, -1, 3, 5, 1'b1, 16'h0000);
    send_units(-1, -1, 3, 3, -1, 3, -1, 3, 3, 1'b0, 16'h0001);
    send_units(-1, -1, 4, 3, -1, 4, -1, 3, 4, 1'b0, 16'h0002);
    // same distance as the closest so far
    send_units(-1, -1, 3, 3, -1, 3, -1, 3, 3, 1'b0, 16'h0003);
    // behind the origin
    send_units(-1, -1, -2, 3, -1, -2, -1, 3, -2, 1'b0, 16'h0004);
    // degenerate triangle and a plane parallel to the ray
    send_units(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'h0005);
    send_units(0, -1, 0, 0, 1, 0, 0, 0, 5, 1'b0, 16'h0006);
    // hit exactly on a vertex, then on the far edge
    send_units(0, 0, 2, 1, 0, 2, 0, 1, 2, 1'b0, 16'h0007);
    send_units(-1, -1, 1, 1, -1, 1, -1, 1, 1, 1'b0, 16'h0008);
    // distance of one lsb equals epsilon, two lsb passes
    begin
      tri_t t;
      t.v = '{-ONE, -ONE, 1, 3 * ONE, -ONE, 1, -ONE, 3 * ONE, 1};
      t.first = 1'b1;
      t.tag = 16'h0009;
      send(t);
      t.v = '{-ONE, -ONE, 2, 3 * ONE, -ONE, 2, -ONE, 3 * ONE, 2};
      t.first = 1'b0;
      t.tag = 16'h000A;
      send(t);
    end
    send_raw(32'h7FFFFFFF, 1'b0, 16'hFFFF);
    send_raw(32'h80000000, 1'b1, 16'h5555);
    send_raw(32'hFFFFFFFF, 1'b0, 16'hAAAA);
    begin
      tri_t t;
      t.v = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000};
      t.first = 1'b0;
      t.tag = 16'h1234;
      send(t);
    end
    drain();

    item_no = 0;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_ray(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h80000000,
                     32'h7FFFFFFF, 16'hFFFF, 31'h7FFFFFFF);
        1: write_ray(0, 0, 0, ONE, 0, 0, 16'h0000, 31'h0);
        2: write_ray(srand(1 << 20), srand(1 << 20), srand(1 << 20), 0, 0, -ONE,
                     16'hFFFF, 31'h7FFFFFFF);
        default: write_ray(srand(1 << 20), srand(1 << 20), srand(1 << 20),
                           srand(1 << 17), srand(1 << 17), srand(1 << 17),
                           $urandom_range(0, 65535), $urandom_range(1 << 16, 31'h7FFFFFFF));
      endcase
      for (int n = 0; n < 155; n++) begin
        calm = (item_no >= 500 && item_no < 650);
        if ($urandom_range(0, 99) < 25) send_noise();
        else send_on_ray(n == 0 || $urandom_range(0, 99) < 8);
        item_no++;
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ray_triangle_closest_hit_unit: match");
    end else begin
      $display("ray_triangle_closest_hit_unit: mismatch");
    end
    $finish;
  end

endmodule
